@@ rtl/core/cht_pkg.sv @@
// Shared types and constants of the chained hash table.
`default_nettype none
package cht_pkg;
   localparam int unsigned CFG_W = 11;
   localparam int unsigned MAX_SLOTS = 1024;
   localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
   localparam logic [31:0] HASH_MUL = 32'd37;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;
endpackage
`default_nettype wire

@@ rtl/core/cht_if.sv @@
// Valid/ready channels of the chained hash table.
`default_nettype none
interface cht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] key;
   logic [31:0] value;
   logic [9:0]  slot;
   modport source (output valid, op, key, value, slot, input ready);
   modport sink (input valid, op, key, value, slot, output ready);
endinterface

interface cht_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] data;
   logic [10:0] fill_count;
   logic [1:0]  status;
   modport source (output valid, found, data, fill_count, status, input ready);
   modport sink (input valid, found, data, fill_count, status, output ready);
endinterface

interface cht_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cht_front.sv @@
// Front end: accepts words, hashes the key and reduces it to a bucket.
`default_nettype none
module cht_front #(
   parameter int unsigned IDX_W = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [1:0]       in_op,
   input  wire logic [31:0]      in_key,
   input  wire logic [31:0]      in_value,
   input  wire logic [IDX_W-1:0] in_slot,
   input  wire logic [IDX_W:0]   size,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [1:0]            out_op,
   output logic [31:0]           out_key,
   output logic [31:0]           out_value,
   output logic [IDX_W-1:0]      out_slot,
   output logic [IDX_W-1:0]      out_bucket
);
   // remainder by restoring subtraction, one bit a cycle
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [31:0]       hash_ff, hash_in;
   logic [IDX_W:0]    rem_ff, rem_in;
   logic [1:0]        op_ff;
   logic [31:0]       key_ff, val_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [IDX_W+1:0]  trial;

   assign in_ready  = !busy_ff && !done_ff;
   assign out_valid = done_ff;
   assign out_op    = op_ff;
   assign out_key   = key_ff;
   assign out_value = val_ff;
   assign out_slot  = slot_ff;
   assign out_bucket = rem_ff[IDX_W-1:0];
   assign trial = {rem_ff, hash_ff[31]} - {1'b0, size};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      hash_in = hash_ff;
      rem_in  = rem_ff;
      if (in_valid && in_ready) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         hash_in = in_key * cht_pkg::HASH_MUL;
         rem_in  = '0;
      end else if (busy_ff) begin
         hash_in = {hash_ff[30:0], 1'b0};
         if (!trial[IDX_W+1]) begin
            rem_in = trial[IDX_W:0];
         end else begin
            rem_in = {rem_ff[IDX_W-1:0], hash_ff[31]};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && out_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
      if (in_valid && in_ready) begin
         op_ff   <= in_op;
         key_ff  <= in_key;
         val_ff  <= in_value;
         slot_ff <= in_slot;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/cht_fifo.sv @@
// Two-entry queue between front and back ends.
`default_nettype none
module cht_fifo #(
   parameter int unsigned W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [W-1:0] in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [W-1:0]      out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

@@ rtl/core/cht_back.sv @@
// Back end: bucket and node memories, chain walk and result register.
`default_nettype none
module cht_back #(
   parameter int unsigned IDX_W = 10,
   parameter int unsigned SLOTS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [1:0]       in_op,
   input  wire logic [31:0]      in_key,
   input  wire logic [31:0]      in_value,
   input  wire logic [IDX_W-1:0] in_slot,
   input  wire logic [IDX_W-1:0] in_bucket,
   input  wire logic [IDX_W:0]   size,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_found,
   output logic [31:0]           rsp_data,
   output logic [IDX_W:0]        rsp_fill,
   output logic [1:0]            rsp_status
);
   typedef enum logic [6:0] {
      S_SWEEP = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HEAD  = 7'b0000100,
      S_NODE  = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // bucket used flags with an epoch per clear avoid a clearing pass
   logic [31:0]      bkt_epoch [SLOTS];
   logic [IDX_W-1:0] bkt_head [SLOTS];
   logic [31:0]      n_key [SLOTS];
   logic [31:0]      n_val [SLOTS];
   logic [IDX_W-1:0] n_next [SLOTS];
   logic             n_last [SLOTS];

   state_type        st_ff, st_in;
   logic [31:0]      epoch_ff;
   logic [IDX_W:0]   used_ff;
   logic [IDX_W-1:0] sweep_ff;
   logic [1:0]       op_ff;
   logic [31:0]      key_ff, val_ff;
   logic [IDX_W-1:0] slot_ff, bkt_ff, cur_ff, tail_ff;
   logic [IDX_W:0]   steps_ff;
   logic             bused_ff, tail_ok_ff;
   logic [31:0]      rd_epoch, rd_key, rd_val;
   logic [IDX_W-1:0] rd_head, rd_next;
   logic             rd_last;
   logic             found_ff;
   logic [31:0]      data_ff;
   logic [1:0]       status_ff;
   logic             key_hit, full;
   logic [IDX_W-1:0] node_addr, bkt_addr;

   assign in_ready   = st_ff == S_IDLE;
   assign rsp_valid  = st_ff == S_DONE;
   assign rsp_found  = found_ff;
   assign rsp_data   = data_ff;
   assign rsp_fill   = used_ff;
   assign rsp_status = status_ff;
   assign key_hit    = rd_key == key_ff;
   assign full       = used_ff >= size;
   assign node_addr  = (st_ff == S_HEAD) ? rd_head : cur_ff;
   // bucket is read as the word is taken so its head is ready in S_HEAD
   assign bkt_addr   = (st_ff == S_IDLE) ? in_bucket : bkt_ff;

   // node and bucket reads, registered
   always_ff @(posedge clock) begin
      rd_epoch <= bkt_epoch[bkt_addr];
      rd_head  <= bkt_head[bkt_addr];
      rd_key   <= n_key[(op_ff == cht_pkg::OP_READ) ? slot_ff : node_addr];
      rd_val   <= n_val[node_addr];
      rd_next  <= n_next[node_addr];
      rd_last  <= n_last[node_addr];
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_SWEEP: if (sweep_ff == IDX_W'(SLOTS - 1)) st_in = S_IDLE;
         S_IDLE:  if (in_valid) st_in = S_HEAD;
         S_HEAD:  st_in = S_NODE;
         S_NODE:  st_in = S_CHECK;
         S_CHECK: st_in = S_WRITE;
         S_WRITE: st_in = S_DONE;
         S_DONE:  if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
      // walking continues from S_CHECK back to S_NODE
      if (st_ff == S_CHECK && (op_ff == cht_pkg::OP_INSERT || op_ff == cht_pkg::OP_LOOKUP)
          && bused_ff && !key_hit && !rd_last && steps_ff < (IDX_W + 1)'(SLOTS - 1)) begin
         st_in = S_NODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_SWEEP;
         used_ff  <= '0;
         epoch_ff <= 32'd1;
         sweep_ff <= '0;
      end else begin
         st_ff <= st_in;
         case (st_ff)
            S_SWEEP: sweep_ff <= sweep_ff + 1'b1;
            S_IDLE: begin
               if (in_valid) begin
                  op_ff  <= in_op;
                  key_ff <= in_key;
                  val_ff <= in_value;
                  slot_ff <= in_slot;
                  bkt_ff <= in_bucket;
               end
               found_ff  <= 1'b0;
               data_ff   <= '0;
               status_ff <= cht_pkg::ST_OK;
               steps_ff  <= '0;
               tail_ok_ff <= 1'b0;
            end
            S_HEAD: begin
               bused_ff <= rd_epoch == epoch_ff;
               cur_ff   <= rd_head;
               tail_ff  <= rd_head;
            end
            S_NODE: ;
            S_CHECK: begin
               case (op_ff)
                  cht_pkg::OP_READ: begin
                     if ({1'b0, slot_ff} < used_ff) data_ff <= rd_key;
                  end
                  cht_pkg::OP_CLEAR: begin
                     used_ff  <= '0;
                     epoch_ff <= epoch_ff + 32'd1;
                  end
                  default: begin
                     if (bused_ff) begin
                        tail_ff    <= cur_ff;
                        tail_ok_ff <= 1'b1;
                        if (key_hit) begin
                           found_ff <= 1'b1;
                           if (op_ff == cht_pkg::OP_LOOKUP) data_ff <= rd_val;
                           else status_ff <= cht_pkg::ST_DUP;
                        end else begin
                           cur_ff   <= rd_next;
                           steps_ff <= steps_ff + 1'b1;
                        end
                     end
                  end
               endcase
            end
            S_WRITE: begin
               if (op_ff == cht_pkg::OP_INSERT && !found_ff) begin
                  if (full) begin
                     status_ff <= cht_pkg::ST_FULL;
                  end else begin
                     used_ff <= used_ff + 1'b1;
                  end
               end
            end
            S_DONE: ;
            default: ;
         endcase
      end
   end

   // memory writes: epoch sweep after reset, then inserts
   always_ff @(posedge clock) begin
      if (!reset && st_ff == S_SWEEP) begin
         bkt_epoch[sweep_ff] <= '0;
      end
      if (!reset && st_ff == S_WRITE && op_ff == cht_pkg::OP_INSERT && !found_ff && !full) begin
         n_key[used_ff[IDX_W-1:0]]  <= key_ff;
         n_val[used_ff[IDX_W-1:0]]  <= val_ff;
         n_last[used_ff[IDX_W-1:0]] <= 1'b1;
         n_next[used_ff[IDX_W-1:0]] <= '0;
         if (!bused_ff) begin
            bkt_epoch[bkt_ff] <= epoch_ff;
            bkt_head[bkt_ff]  <= used_ff[IDX_W-1:0];
         end else if (tail_ok_ff) begin
            n_last[tail_ff] <= 1'b0;
            n_next[tail_ff] <= used_ff[IDX_W-1:0];
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/chained_hash_table_unit.sv @@
// Top level of the chained hash table.
// Channels: req (op, key, value, slot) in, rsp (found, data, fill_count,
// status) out, csr writes table_size; all valid/ready, a word moves when
// both are high. One rsp word per req word, in order.
// Front end: key*37 then a 32-step remainder by the size; it takes no new
// req word until its bucket has been handed to the queue.
// Back end: S_HEAD, S_NODE, S_CHECK, S_WRITE and S_DONE per word, and S_NODE,
// S_CHECK again per chain node walked beyond the first.
// The front end can hash the next word while the back end works; a 2-word
// queue sits between them.
// Reset: synchronous, empties the table and sets table_size to 1024; the
// back end then marks every bucket empty in a sweep, and req
// stalls once the queue is full. Clear needs no sweep: buckets carry an epoch.
// A stalled rsp holds the back end; the queue then fills and req stalls.
// table_size 0 acts as 1 and values above MAX_SLOTS act as MAX_SLOTS.
// csr writes are always accepted; write only when idle.
`default_nettype none
module chained_hash_table_unit (
   input wire logic clock,
   input wire logic reset,
   cht_req_if.sink  req,
   cht_rsp_if.source rsp,
   cht_csr_if.sink  csr
);
   localparam int unsigned MAX_SLOTS = cht_pkg::MAX_SLOTS;
   localparam int unsigned IDX_W = cht_pkg::IDX_W;
   localparam int unsigned QW = 2 + 32 + 32 + 2 * IDX_W;

   logic [cht_pkg::CFG_W-1:0] size_ff;
   logic [IDX_W:0]            eff_size;
   logic                      f_valid, f_ready, b_valid, b_ready;
   logic [1:0]                f_op;
   logic [31:0]               f_key, f_val;
   logic [IDX_W-1:0]          f_slot, f_bkt;
   logic [QW-1:0]             q_in, q_out;
   logic [IDX_W:0]            fill;

   // size register and clamp
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= 11'd1024;
      else if (csr.valid) size_ff <= csr.data;
   end
   always_comb begin
      if (size_ff == '0) eff_size = (IDX_W + 1)'(1);
      else if (32'(size_ff) > MAX_SLOTS) eff_size = (IDX_W + 1)'(MAX_SLOTS);
      else eff_size = (IDX_W + 1)'(size_ff);
   end

   cht_front #(.IDX_W(IDX_W)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_op(req.op),
      .in_key(req.key), .in_value(req.value), .in_slot(IDX_W'(req.slot)),
      .size(eff_size),
      .out_valid(f_valid), .out_ready(f_ready), .out_op(f_op), .out_key(f_key),
      .out_value(f_val), .out_slot(f_slot), .out_bucket(f_bkt)
   );

   assign q_in = {f_op, f_key, f_val, f_slot, f_bkt};

   cht_fifo #(.W(QW)) u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(q_in),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(q_out)
   );

   cht_back #(.IDX_W(IDX_W), .SLOTS(MAX_SLOTS)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready),
      .in_op(q_out[QW-1 -: 2]), .in_key(q_out[QW-3 -: 32]),
      .in_value(q_out[QW-35 -: 32]), .in_slot(q_out[2*IDX_W-1 -: IDX_W]),
      .in_bucket(q_out[IDX_W-1:0]), .size(eff_size),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.found),
      .rsp_data(rsp.data), .rsp_fill(fill), .rsp_status(rsp.status)
   );
   assign rsp.fill_count = 11'(fill);

   // checks
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> fill <= (IDX_W + 1)'(MAX_SLOTS)) else $error("fill overflow");
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == cht_pkg::ST_FULL |-> !rsp.found)
      else $error("full with found");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp dropped");
endmodule
`default_nettype wire

@@ tb/cht_tb_checker.sv @@
// Checker for the chained hash table: watches the channels, predicts every response and compares.
module cht_tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   input  logic [9:0]  req_slot,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [31:0] rsp_data,
   input  logic [10:0] rsp_fill_count,
   input  logic [1:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS = 1024;

   typedef struct packed {
      logic                 found;
      logic [31:0]          data;
      logic [10:0]          fill_count;
      cht_pkg::status_type  status;
   } answer_type;

   // shadow of the table
   logic [10:0] size_reg;
   logic        bkt_used [SLOTS];
   logic [9:0]  bkt_head [SLOTS];
   logic [31:0] nd_key   [SLOTS];
   logic [31:0] nd_val   [SLOTS];
   logic [9:0]  nd_next  [SLOTS];
   logic        nd_last  [SLOTS];
   int unsigned fill;
   answer_type  answers_due [$];

   function automatic int unsigned live_size();
      if (size_reg == 0) return 1;
      if (size_reg > SLOTS) return SLOTS;
      return size_reg;
   endfunction

   // apply one request to the shadow and return its answer
   function automatic answer_type apply_request(logic [1:0] op, logic [31:0] k,
                                                logic [31:0] v, logic [9:0] s);
      answer_type  a;
      logic [31:0] h;
      int unsigned b, n, tail, hit, steps;
      logic        present;
      a = '0;
      a.status = cht_pkg::ST_OK;
      present = 1'b0;
      hit = 0;
      tail = 0;
      if (op == cht_pkg::OP_INSERT || op == cht_pkg::OP_LOOKUP) begin
         h = k * cht_pkg::HASH_MUL;
         b = h % live_size();
         // chain walk
         if (bkt_used[b]) begin
            n = bkt_head[b];
            for (steps = 0; steps < SLOTS; steps++) begin
               tail = n;
               if (nd_key[n] == k) begin
                  present = 1'b1;
                  hit = n;
                  break;
               end
               if (nd_last[n]) break;
               n = nd_next[n];
            end
         end
         if (op == cht_pkg::OP_LOOKUP) begin
            if (present) begin
               a.found = 1'b1;
               a.data = nd_val[hit];
            end
         end else if (present) begin
            a.found = 1'b1;
            a.status = cht_pkg::ST_DUP;
         end else if (fill >= live_size()) begin
            a.status = cht_pkg::ST_FULL;
         end else begin
            nd_key[fill] = k;
            nd_val[fill] = v;
            nd_next[fill] = '0;
            nd_last[fill] = 1'b1;
            if (!bkt_used[b]) begin
               bkt_used[b] = 1'b1;
               bkt_head[b] = fill[9:0];
            end else begin
               nd_last[tail] = 1'b0;
               nd_next[tail] = fill[9:0];
            end
            fill++;
         end
      end else if (op == cht_pkg::OP_CLEAR) begin
         foreach (bkt_used[i]) bkt_used[i] = 1'b0;
         fill = 0;
      end else if (s < fill) begin
         a.data = nd_key[s];
      end
      a.fill_count = fill[10:0];
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type e;
      int         errs;
      errs = 0;
      if (reset) begin
         size_reg <= 11'd1024;
         foreach (bkt_used[i]) bkt_used[i] = 1'b0;
         fill = 0;
         answers_due.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) size_reg <= csr_data;
         if (req_valid && req_ready)
            answers_due.push_back(apply_request(req_op, req_key, req_value, req_slot));
         // compare each accepted response word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected response word");
               errs++;
            end else begin
               e = answers_due.pop_front();
               if (rsp_found !== e.found) begin
                  $error("found: expected %0d got %0d", e.found, rsp_found);
                  errs++;
               end
               if (rsp_data !== e.data) begin
                  $error("data: expected %0h got %0h", e.data, rsp_data);
                  errs++;
               end
               if (rsp_fill_count !== e.fill_count) begin
                  $error("fill_count: expected %0d got %0d", e.fill_count, rsp_fill_count);
                  errs++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d got %0d", e.status, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= answers_due.size();
      end
   end
endmodule

@@ tb/tb_chained_hash_table_unit.sv @@
// Testbench top for the chained hash table: stimulus, idling and verdict.
module tb_chained_hash_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic [31:0] keys_seen [$];

   cht_req_if req ();
   cht_rsp_if rsp ();
   cht_csr_if csr ();

   chained_hash_table_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   cht_tb_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_op         (req.op),
      .req_key        (req.key),
      .req_value      (req.value),
      .req_slot       (req.slot),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_found      (rsp.found),
      .rsp_data       (rsp.data),
      .rsp_fill_count (rsp.fill_count),
      .rsp_status     (rsp.status),
      .csr_valid      (csr.valid),
      .csr_ready      (csr.ready),
      .csr_data       (csr.data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // send one request word, with random idle cycles first
   task automatic send_word(cht_pkg::op_type op, logic [31:0] k, logic [31:0] v,
                            logic [9:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.op    <= op;
      req.key   <= k;
      req.value <= v;
      req.slot  <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (op == cht_pkg::OP_INSERT) keys_seen.push_back(k);
   endtask

   // let everything drain, then write the size register while idle and clear the table
   task automatic set_size(logic [10:0] sz);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= sz;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      send_word(cht_pkg::OP_CLEAR, '0, '0, '0);
      keys_seen.delete();
   endtask

   // mostly inserts and lookups, often of keys already inserted
   task automatic random_word(int unsigned key_span);
      int unsigned pick;
      logic [31:0] k;
      pick = $urandom_range(99);
      if (keys_seen.size() != 0 && $urandom_range(1))
         k = keys_seen[$urandom_range(keys_seen.size() - 1)];
      else if ($urandom_range(3) == 0)
         k = $urandom();
      else
         k = $urandom_range(key_span);
      if (pick < 45) send_word(cht_pkg::OP_INSERT, k, $urandom(), 10'($urandom()));
      else if (pick < 85) send_word(cht_pkg::OP_LOOKUP, k, $urandom(), 10'($urandom()));
      else if (pick < 87) begin
         send_word(cht_pkg::OP_CLEAR, $urandom(), $urandom(), 10'($urandom()));
         keys_seen.delete();
      end else send_word(cht_pkg::OP_READ, $urandom(), $urandom(),
                         10'($urandom_range(1023)));
   endtask

   initial begin
      logic [10:0] sizes [6];
      req.valid <= 1'b0;
      req.op    <= cht_pkg::OP_INSERT;
      req.key   <= '0;
      req.value <= '0;
      req.slot  <= '0;
      csr.valid <= 1'b0;
      csr.data  <= '0;
      sizes = '{11'd1, 11'd0, 11'd7, 11'd2047, 11'd1024, 11'd33};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty lookup, duplicate, read past fill
      send_word(cht_pkg::OP_LOOKUP, 32'd5, '0, '0);
      send_word(cht_pkg::OP_READ, '0, '0, 10'd0);
      send_word(cht_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF, 10'h3FF);
      send_word(cht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'd0, '0);
      send_word(cht_pkg::OP_INSERT, 32'd1024, 32'h1234_5678, '0);
      send_word(cht_pkg::OP_INSERT, 32'd0, 32'd9, '0);
      send_word(cht_pkg::OP_LOOKUP, 32'd1024, '0, '0);
      send_word(cht_pkg::OP_LOOKUP, 32'd0, '0, '0);
      send_word(cht_pkg::OP_LOOKUP, 32'd2048, '0, '0);
      send_word(cht_pkg::OP_READ, '0, '0, 10'd2);
      send_word(cht_pkg::OP_READ, '0, '0, 10'd3);
      send_word(cht_pkg::OP_READ, '0, '0, 10'h3FF);
      send_word(cht_pkg::OP_CLEAR, '0, '0, '0);
      send_word(cht_pkg::OP_LOOKUP, 32'd0, '0, '0);
      // tiny table: pool full, duplicate on a full pool
      set_size(11'd2);
      send_word(cht_pkg::OP_INSERT, 32'd10, 32'd1, '0);
      send_word(cht_pkg::OP_INSERT, 32'd11, 32'd2, '0);
      send_word(cht_pkg::OP_INSERT, 32'd12, 32'd3, '0);
      send_word(cht_pkg::OP_INSERT, 32'd10, 32'd4, '0);
      send_word(cht_pkg::OP_LOOKUP, 32'd11, '0, '0);
      // shrink without clearing: chains stay walkable
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= 11'd1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      send_word(cht_pkg::OP_LOOKUP, 32'd10, '0, '0);
      send_word(cht_pkg::OP_INSERT, 32'd13, 32'd5, '0);

      // random phases, idling patterns, several sizes
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 19;
            recv_idle_pct = 69;
         end else if (ph < 4) begin
            send_idle_pct = 69;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_size(sizes[ph]);
         for (int i = 0; i < 305; i++)
            random_word((sizes[ph] > 64) ? 300 : 20);
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #25ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
